// File: src/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg
// Shared constants, types and the microcode table of the longest increasing
// subsequence block.
// ----------------------------------------------------------------------------
package lis_pkg;

  // store depth and derived widths
  localparam int MAX_ITEMS = 64;
  localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int VAL_W     = 32;
  localparam int LEN_W     = 7;

  // program steps
  typedef enum logic [4:0] {
    S_WAIT, S_I_INIT, S_RD_I, S_LD_I, S_J_TEST, S_RD_J, S_EV_J, S_WR_I,
    S_M_INIT, S_M_RD, S_M_EV, S_T_INIT, S_T_RD, S_T_LD, S_T_RDJ, S_T_EVJ,
    S_O_INIT, S_O_RDP, S_O_RDV, S_O_SEND, S_FIN
  } step_t;

  // hold conditions
  typedef enum logic [1:0] {W_NONE, W_IN, W_OUT} wait_t;

  // memory read address source
  typedef enum logic [1:0] {A_I, A_J, A_CUR, A_PATH} addr_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_INIT_I, OP_LOAD_I, OP_EVAL_J, OP_WRITE_I,
    OP_MAX_INIT, OP_MAX_EVAL, OP_TB_INIT, OP_TB_LOAD, OP_TB_EVAL,
    OP_OUT_INIT, OP_SEND, OP_FINISH
  } op_t;

  // branch conditions
  typedef enum logic [2:0] {
    C_ALWAYS, C_LAST_IN, C_J_DONE, C_I_DONE, C_K_ONE, C_MATCH, C_K_LAST
  } cond_t;

  // one control word
  typedef struct packed {
    wait_t wait_sel;
    addr_t addr_sel;
    op_t   op;
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic in_fire;
    logic out_free;
    logic last_in;
    logic j_done;
    logic i_done;
    logic k_one;
    logic match;
    logic k_last;
  } stat_t;

  function automatic ctrl_t cw(wait_t w, addr_t a, op_t o, cond_t c,
                               step_t t, step_t f);
    ctrl_t r;
    r.wait_sel = w;
    r.addr_sel = a;
    r.op       = o;
    r.cond     = c;
    r.tgt_t    = t;
    r.tgt_f    = f;
    return r;
  endfunction

  // microcode table
  function automatic ctrl_t ucode(step_t s);
    ctrl_t r;
    unique case (s)
      S_WAIT:   r = cw(W_IN,   A_I,    OP_LOAD,     C_LAST_IN, S_I_INIT, S_WAIT);
      S_I_INIT: r = cw(W_NONE, A_I,    OP_INIT_I,   C_ALWAYS,  S_RD_I,   S_RD_I);
      S_RD_I:   r = cw(W_NONE, A_I,    OP_NOP,      C_ALWAYS,  S_LD_I,   S_LD_I);
      S_LD_I:   r = cw(W_NONE, A_I,    OP_LOAD_I,   C_ALWAYS,  S_J_TEST, S_J_TEST);
      S_J_TEST: r = cw(W_NONE, A_J,    OP_NOP,      C_J_DONE,  S_WR_I,   S_RD_J);
      S_RD_J:   r = cw(W_NONE, A_J,    OP_NOP,      C_ALWAYS,  S_EV_J,   S_EV_J);
      S_EV_J:   r = cw(W_NONE, A_J,    OP_EVAL_J,   C_ALWAYS,  S_J_TEST, S_J_TEST);
      S_WR_I:   r = cw(W_NONE, A_I,    OP_WRITE_I,  C_I_DONE,  S_M_INIT, S_RD_I);
      S_M_INIT: r = cw(W_NONE, A_I,    OP_MAX_INIT, C_ALWAYS,  S_M_RD,   S_M_RD);
      S_M_RD:   r = cw(W_NONE, A_I,    OP_NOP,      C_ALWAYS,  S_M_EV,   S_M_EV);
      S_M_EV:   r = cw(W_NONE, A_I,    OP_MAX_EVAL, C_I_DONE,  S_T_INIT, S_M_RD);
      S_T_INIT: r = cw(W_NONE, A_CUR,  OP_TB_INIT,  C_ALWAYS,  S_T_RD,   S_T_RD);
      S_T_RD:   r = cw(W_NONE, A_CUR,  OP_NOP,      C_ALWAYS,  S_T_LD,   S_T_LD);
      S_T_LD:   r = cw(W_NONE, A_CUR,  OP_TB_LOAD,  C_K_ONE,   S_O_INIT, S_T_RDJ);
      S_T_RDJ:  r = cw(W_NONE, A_J,    OP_NOP,      C_ALWAYS,  S_T_EVJ,  S_T_EVJ);
      S_T_EVJ:  r = cw(W_NONE, A_J,    OP_TB_EVAL,  C_MATCH,   S_T_RD,   S_T_RDJ);
      S_O_INIT: r = cw(W_NONE, A_PATH, OP_OUT_INIT, C_ALWAYS,  S_O_RDP,  S_O_RDP);
      S_O_RDP:  r = cw(W_NONE, A_PATH, OP_NOP,      C_ALWAYS,  S_O_RDV,  S_O_RDV);
      S_O_RDV:  r = cw(W_NONE, A_PATH, OP_NOP,      C_ALWAYS,  S_O_SEND, S_O_SEND);
      S_O_SEND: r = cw(W_OUT,  A_PATH, OP_SEND,     C_K_LAST,  S_FIN,    S_O_RDP);
      S_FIN:    r = cw(W_NONE, A_I,    OP_FINISH,   C_ALWAYS,  S_WAIT,   S_WAIT);
      default:  r = cw(W_NONE, A_I,    OP_NOP,      C_ALWAYS,  S_WAIT,   S_WAIT);
    endcase
    return r;
  endfunction

endpackage

// File: src/lis_in_if.sv
// ----------------------------------------------------------------------------
// lis_in_if
// Input channel: one sequence element per item, with a closing flag.
// ----------------------------------------------------------------------------
interface lis_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [lis_pkg::VAL_W-1:0]    value;
  logic                                last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// File: src/lis_out_if.sv
// ----------------------------------------------------------------------------
// lis_out_if
// Output channel: one subsequence member per item.
// ----------------------------------------------------------------------------
interface lis_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lis_pkg::VAL_W-1:0]    element;
  logic        [lis_pkg::LEN_W-1:0]    length;
  logic                                overflow;
  logic                                end_of_run;

  modport source (output valid, output element, output length, output overflow,
                  output end_of_run, input ready);
  modport sink   (input valid, input element, input length, input overflow,
                  input end_of_run, output ready);
endinterface

// File: src/lis_seq.sv
// ----------------------------------------------------------------------------
// lis_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module lis_seq (
  input  logic             clk,
  input  logic             rst,
  input  lis_pkg::stat_t   stat,
  output lis_pkg::ctrl_t   ctrl
);

  lis_pkg::step_t pc;
  lis_pkg::step_t pc_next;
  logic           hold;
  logic           taken;

  // control word of the current step
  always_comb begin
    ctrl = lis_pkg::ucode(pc);
  end

  // hold and branch decision
  always_comb begin
    unique case (ctrl.wait_sel)
      lis_pkg::W_IN:  hold = !stat.in_fire;
      lis_pkg::W_OUT: hold = !stat.out_free;
      default:        hold = 1'b0;
    endcase
    unique case (ctrl.cond)
      lis_pkg::C_LAST_IN: taken = stat.last_in;
      lis_pkg::C_J_DONE:  taken = stat.j_done;
      lis_pkg::C_I_DONE:  taken = stat.i_done;
      lis_pkg::C_K_ONE:   taken = stat.k_one;
      lis_pkg::C_MATCH:   taken = stat.match;
      lis_pkg::C_K_LAST:  taken = stat.k_last;
      default:            taken = 1'b1;
    endcase
  end

  // next step
  always_comb begin
    if (hold) begin
      pc_next = pc;
    end else if (taken) begin
      pc_next = ctrl.tgt_t;
    end else begin
      pc_next = ctrl.tgt_f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= lis_pkg::S_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: src/longest_increasing_subsequence_top.sv
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_top
// Longest strictly increasing subsequence by the quadratic dynamic programme.
//
// Elements come in on items, one per item; the item with last set closes the
// sequence. Elements past the store depth are dropped and flagged. While
// loading, one item is taken per cycle. After the closing item the block
// fills the length table (each compare steps through S_J_TEST, S_RD_J and
// S_EV_J, using the registered memory reads), finds the first maximum,
// traces back, then sends the subsequence front to back on results, reading
// each member through S_O_RDP and S_O_RDV and sending it from S_O_SEND before
// the next is fetched, each carrying the total length, the overflow flag and
// end_of_run on the final member. No new element is taken until the last
// result has been loaded into the output register. A stalled receiver holds
// the output register and the sequencer waits; nothing is lost. Reset empties
// the store count and overflow flag; the store contents need no clearing.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_top (
  input  logic         clk,
  input  logic         rst,
  lis_in_if.sink       items,
  lis_out_if.source    results
);

  localparam int IW = lis_pkg::IDX_W;
  localparam int CW = lis_pkg::CNT_W;
  localparam int VW = lis_pkg::VAL_W;

  lis_pkg::ctrl_t ctrl;
  lis_pkg::stat_t stat;

  // stores
  logic signed [VW-1:0] value_mem  [lis_pkg::MAX_ITEMS];
  logic        [CW-1:0] length_mem [lis_pkg::MAX_ITEMS];
  logic        [IW-1:0] path_mem   [lis_pkg::MAX_ITEMS];

  // datapath registers
  logic        [CW-1:0] cnt;
  logic                 ovf;
  logic        [IW-1:0] i;
  logic        [IW-1:0] j;
  logic        [IW-1:0] cur;
  logic        [IW-1:0] pos;
  logic        [CW-1:0] k;
  logic        [CW-1:0] len;
  logic        [CW-1:0] best;
  logic signed [VW-1:0] vi;
  logic        [CW-1:0] li;
  logic signed [VW-1:0] rd_val;
  logic        [CW-1:0] rd_len;
  logic        [IW-1:0] rd_path;
  logic        [IW-1:0] rd_addr;

  // output register
  logic                 ov;
  logic signed [VW-1:0] o_element;
  logic [lis_pkg::LEN_W-1:0] o_length;
  logic                 o_overflow;
  logic                 o_end;

  logic                 room;
  logic                 smaller;
  logic        [CW-1:0] rd_len_inc;

  lis_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // handshakes
  assign items.ready        = (ctrl.wait_sel == lis_pkg::W_IN) && !rst;
  assign results.valid      = ov;
  assign results.element    = o_element;
  assign results.length     = o_length;
  assign results.overflow   = o_overflow;
  assign results.end_of_run = o_end;

  // comparisons
  assign room       = (cnt < CW'(lis_pkg::MAX_ITEMS));
  assign smaller    = (rd_val < vi);
  assign rd_len_inc = rd_len + CW'(1);

  // status to the sequencer
  always_comb begin
    stat.in_fire  = items.valid && items.ready;
    stat.out_free = !ov || results.ready;
    stat.last_in  = items.last;
    stat.j_done   = (j == i);
    stat.i_done   = (CW'(i) + CW'(1) == cnt);
    stat.k_one    = (k == CW'(1));
    stat.match    = smaller && (li == rd_len_inc);
    stat.k_last   = (k + CW'(1) == len);
  end

  // read address select
  always_comb begin
    unique case (ctrl.addr_sel)
      lis_pkg::A_J:    rd_addr = j;
      lis_pkg::A_CUR:  rd_addr = cur;
      lis_pkg::A_PATH: rd_addr = rd_path;
      default:         rd_addr = i;
    endcase
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (ctrl.op == lis_pkg::OP_LOAD && stat.in_fire && room) begin
      value_mem[cnt[IW-1:0]] <= items.value;
    end
    if (ctrl.op == lis_pkg::OP_WRITE_I) begin
      length_mem[i] <= li;
    end
    if (ctrl.op == lis_pkg::OP_TB_LOAD) begin
      path_mem[IW'(k - CW'(1))] <= cur;
    end
    rd_val  <= value_mem[rd_addr];
    rd_len  <= length_mem[rd_addr];
    rd_path <= path_mem[k[IW-1:0]];
  end

  // store count and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ovf <= 1'b0;
    end else if (ctrl.op == lis_pkg::OP_LOAD && stat.in_fire) begin
      if (room) begin
        cnt <= cnt + CW'(1);
      end else begin
        ovf <= 1'b1;
      end
    end else if (ctrl.op == lis_pkg::OP_FINISH) begin
      cnt <= '0;
      ovf <= 1'b0;
    end
  end

  // datapath operations
  always_ff @(posedge clk) begin
    case (ctrl.op)
      lis_pkg::OP_INIT_I: begin
        i <= '0;
      end
      lis_pkg::OP_LOAD_I: begin
        vi <= rd_val;
        li <= CW'(1);
        j  <= '0;
      end
      lis_pkg::OP_EVAL_J: begin
        if (smaller && li <= rd_len) begin
          li <= rd_len_inc;
        end
        j <= j + IW'(1);
      end
      lis_pkg::OP_WRITE_I: begin
        i <= i + IW'(1);
      end
      lis_pkg::OP_MAX_INIT: begin
        i    <= '0;
        best <= '0;
        pos  <= '0;
      end
      lis_pkg::OP_MAX_EVAL: begin
        if (best < rd_len) begin
          best <= rd_len;
          pos  <= i;
        end
        i <= i + IW'(1);
      end
      lis_pkg::OP_TB_INIT: begin
        cur <= pos;
        k   <= best;
        len <= best;
      end
      lis_pkg::OP_TB_LOAD: begin
        vi <= rd_val;
        li <= rd_len;
        k  <= k - CW'(1);
        j  <= '0;
      end
      lis_pkg::OP_TB_EVAL: begin
        if (stat.match) begin
          cur <= j;
        end else begin
          j <= j + IW'(1);
        end
      end
      lis_pkg::OP_OUT_INIT: begin
        k <= '0;
      end
      lis_pkg::OP_SEND: begin
        if (stat.out_free) begin
          k <= k + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (ctrl.op == lis_pkg::OP_SEND && stat.out_free) begin
      ov <= 1'b1;
    end else if (results.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == lis_pkg::OP_SEND && stat.out_free) begin
      o_element  <= rd_val;
      o_length   <= lis_pkg::LEN_W'(len);
      o_overflow <= ovf;
      o_end      <= stat.k_last;
    end
  end

`ifndef SYNTHESIS
  // store count never passes the depth
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(lis_pkg::MAX_ITEMS))
    else $error("item count beyond store depth");

  // inner fill loop only visits earlier elements
  a_fill_order: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == lis_pkg::OP_EVAL_J |-> j < i)
    else $error("fill compare past current element");

  // traceback finds a predecessor before reaching the current position
  a_trace_order: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == lis_pkg::OP_TB_EVAL |-> j < cur)
    else $error("traceback search ran past current position");

  // a result appears only from the send step
  a_send_src: assert property (@(posedge clk) disable iff (rst)
    $rose(ov) |-> $past(ctrl.op == lis_pkg::OP_SEND))
    else $error("result valid without a send step");
`endif

endmodule
